/* rtl/lgwp_pkg.sv */
// ----------------------------------------------------------------------------
// lgwp_pkg
// Shared types, constants and helpers for the line grep with wrap pick block.
// ----------------------------------------------------------------------------
package lgwp_pkg;

  // Pattern storage and counter sizing
  localparam int MAX_PATTERN = 32;
  localparam int LINE_BITS   = 16;
  localparam int PAT_WORDS   = 4;
  localparam int PAT_CHARS   = PAT_WORDS * 8;
  localparam int PAT_BITS    = PAT_CHARS * 8;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CUR_W       = 17;
  localparam int CMP_W       = ((LINE_BITS > 16) ? LINE_BITS : 16) + 2;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef logic [LINE_BITS-1:0] line_t;

  localparam line_t COUNT_TOP = {LINE_BITS{1'b1}};

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PATTERN_LEN = 3'd0,
    CFG_WORD0       = 3'd1,
    CFG_WORD1       = 3'd2,
    CFG_WORD2       = 3'd3,
    CFG_WORD3       = 3'd4,
    CFG_CUR_LINE    = 3'd5,
    CFG_DIRECTION   = 3'd6
  } cfg_idx_t;

  // One result transaction
  typedef struct packed {
    logic [15:0] line_index;
    logic        line_hit;
    logic        final_report;
    logic [15:0] hit_total;
    logic        pick_found;
    logic [15:0] picked_line;
  } result_t;

  // ASCII upper case letters fold to lower case, all else unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'd65 && b <= 8'd90) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

/* rtl/lgwp_cell.sv */
// ----------------------------------------------------------------------------
// lgwp_cell
// One prefix cell: remembers whether the pattern prefix ending at this
// character matched up to the previous byte, and hands it to the next cell.
// ----------------------------------------------------------------------------
module lgwp_cell
  import lgwp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       clear,
  input  logic       is_nl,
  input  logic [7:0] byte_fold,
  input  logic [7:0] pat_char,
  input  logic       prev_in,
  input  logic       tail,
  output logic       prefix_out,
  output logic       hit_out
);

  logic prefix_r;
  logic prefix_nxt;
  logic match_c;

  // Prefix extends when the neighbor matched and this character agrees
  assign match_c    = prev_in && (byte_fold == fold_case(pat_char));
  assign hit_out    = tail && match_c && !is_nl;
  assign prefix_nxt = clear ? 1'b0 : match_c;
  assign prefix_out = prefix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 1'b0;
    end else if (en) begin
      prefix_r <= prefix_nxt;
    end
  end

endmodule

/* rtl/lgwp_chain.sv */
// ----------------------------------------------------------------------------
// lgwp_chain
// Row of prefix cells, one per pattern character. Flags a pattern hit on
// the current byte.
// ----------------------------------------------------------------------------
module lgwp_chain
  import lgwp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                is_nl,
  input  logic                last,
  input  logic [7:0]          text_byte,
  input  logic [PAT_BITS-1:0] pattern,
  input  logic [5:0]          pattern_len,
  output logic                hit_now
);

  logic [7:0]             byte_fold;
  logic [LEN_W-1:0]       len_eff;
  logic [MAX_PATTERN:0]   link;
  logic [MAX_PATTERN-1:0] cell_hit;

  assign byte_fold = fold_case(text_byte);

  // Lengths beyond the chain are clamped to its depth
  always_comb begin
    if (32'(pattern_len) > MAX_PATTERN) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(pattern_len);
    end
  end

  // Cell zero always sees a matched empty prefix
  assign link[0] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] pchar;
    logic       tail;

    if (k < PAT_CHARS) begin : g_char
      assign pchar = pattern[8*k +: 8];
    end else begin : g_zero
      assign pchar = 8'd0;
    end

    assign tail = (32'(len_eff) == k + 1);

    lgwp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .clear      (is_nl || last),
      .is_nl      (is_nl),
      .byte_fold  (byte_fold),
      .pat_char   (pchar),
      .prev_in    (link[k]),
      .tail       (tail),
      .prefix_out (link[k+1]),
      .hit_out    (cell_hit[k])
    );
  end

  // Only the cell at the pattern end can raise a hit; empty pattern has none
  assign hit_now = |cell_hit;

endmodule

/* rtl/lgwp_tally.sv */
// ----------------------------------------------------------------------------
// lgwp_tally
// Line and hit counters, hit position tracking and the next or previous
// hit pick made on the last byte of a body.
// ----------------------------------------------------------------------------
module lgwp_tally
  import lgwp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             is_nl,
  input  logic             last,
  input  logic             hit_now,
  input  logic [CUR_W-1:0] current_line,
  input  logic             direction,
  output logic             produce,
  output result_t          result
);

  line_t line_cnt_r,    line_cnt_nxt;
  logic  hit_line_r,    hit_line_nxt;
  line_t hit_cnt_r,     hit_cnt_nxt;
  line_t first_hit_r,   first_hit_nxt;
  line_t last_hit_r,    last_hit_nxt;
  line_t first_after_r, first_after_nxt;
  logic  after_seen_r,  after_seen_nxt;
  line_t last_before_r, last_before_nxt;
  logic  before_seen_r, before_seen_nxt;

  logic              hil;
  logic              line_end;
  logic signed [CMP_W-1:0] ln_s;
  logic signed [CMP_W-1:0] cur_s;
  logic              found;
  line_t             picked;

  assign hil      = hit_line_r || hit_now;
  assign line_end = is_nl || last;
  assign produce  = line_end;
  assign ln_s     = {{(CMP_W-LINE_BITS){1'b0}}, line_cnt_r};
  assign cur_s    = {{(CMP_W-CUR_W){current_line[CUR_W-1]}}, current_line};

  // Bookkeeping for a line that ends with a hit
  always_comb begin
    hit_cnt_nxt     = hit_cnt_r;
    first_hit_nxt   = first_hit_r;
    last_hit_nxt    = last_hit_r;
    first_after_nxt = first_after_r;
    after_seen_nxt  = after_seen_r;
    last_before_nxt = last_before_r;
    before_seen_nxt = before_seen_r;
    if (hil) begin
      if (hit_cnt_r == '0) begin
        first_hit_nxt = line_cnt_r;
      end
      last_hit_nxt = line_cnt_r;
      if (ln_s > cur_s && !after_seen_r) begin
        first_after_nxt = line_cnt_r;
        after_seen_nxt  = 1'b1;
      end
      if (ln_s < cur_s) begin
        last_before_nxt = line_cnt_r;
        before_seen_nxt = 1'b1;
      end
      if (hit_cnt_r != COUNT_TOP) begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
      end
    end
  end

  // Wrap pick on the last byte
  always_comb begin
    found  = last && (hit_cnt_nxt != '0);
    picked = '0;
    if (found) begin
      if (!direction) begin
        picked = (!cur_s[CMP_W-1] && after_seen_nxt) ? first_after_nxt : first_hit_nxt;
      end else begin
        picked = (!cur_s[CMP_W-1] && before_seen_nxt) ? last_before_nxt : last_hit_nxt;
      end
    end
  end

  always_comb begin
    result.line_index   = 16'(line_cnt_r);
    result.line_hit     = hil;
    result.final_report = last;
    result.hit_total    = 16'(hit_cnt_nxt);
    result.pick_found   = found;
    result.picked_line  = 16'(picked);
  end

  // Next line number and per-line hit flag
  always_comb begin
    hit_line_nxt = hil;
    line_cnt_nxt = line_cnt_r;
    if (line_end) begin
      hit_line_nxt = 1'b0;
      if (line_cnt_r != COUNT_TOP) begin
        line_cnt_nxt = line_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r    <= '0;
      hit_line_r    <= 1'b0;
      hit_cnt_r     <= '0;
      first_hit_r   <= '0;
      last_hit_r    <= '0;
      first_after_r <= '0;
      after_seen_r  <= 1'b0;
      last_before_r <= '0;
      before_seen_r <= 1'b0;
    end else if (en) begin
      if (last) begin
        // body done: start over at line zero
        line_cnt_r    <= '0;
        hit_line_r    <= 1'b0;
        hit_cnt_r     <= '0;
        first_hit_r   <= '0;
        last_hit_r    <= '0;
        first_after_r <= '0;
        after_seen_r  <= 1'b0;
        last_before_r <= '0;
        before_seen_r <= 1'b0;
      end else begin
        line_cnt_r <= line_cnt_nxt;
        hit_line_r <= hit_line_nxt;
        if (line_end) begin
          hit_cnt_r     <= hit_cnt_nxt;
          first_hit_r   <= first_hit_nxt;
          last_hit_r    <= last_hit_nxt;
          first_after_r <= first_after_nxt;
          after_seen_r  <= after_seen_nxt;
          last_before_r <= last_before_nxt;
          before_seen_r <= before_seen_nxt;
        end
      end
    end
  end

endmodule

/* rtl/lgwp_outbuf.sv */
// ----------------------------------------------------------------------------
// lgwp_outbuf
// Output register with a skid stage so that input keeps flowing while a
// result waits for the receiver.
// ----------------------------------------------------------------------------
module lgwp_outbuf
  import lgwp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_data,
  output logic    skid_full
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    pop;

  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign skid_full = skid_valid_r;

  // Valid flags; push never arrives while the skid stage is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (!out_valid_r) begin
        out_valid_r <= push;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Payload moves
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (!out_valid_r) begin
      if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

/* rtl/line_grep_with_wrap_pick.sv */
// ----------------------------------------------------------------------------
// line_grep_with_wrap_pick
// Case-insensitive per-line pattern search over a byte stream, with a
// wrapping next or previous hit pick at the end of the body.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per transaction,
//   with in_body_end marking the last byte of a body. Ordinary bytes give no
//   result; a newline or the last byte gives one result transaction on the
//   out_ channel (out_valid/out_ready).
//   Throughput: one byte per cycle, unless in_ready is low. Every prefix
//   cell of the chain updates in the cycle the byte is accepted, so nothing
//   loops over the pattern. A result is registered in the output register,
//   or in the skid entry while that register holds an unaccepted result.
//   Stall: results go to an output register backed by one skid entry; input
//   keeps being taken until both hold a result, then in_ready drops until
//   the receiver takes one.
//   Reset: synchronous, active low on rst_n. Registers take their listed
//   reset values (current line -1), counters and the chain clear, and the
//   first byte starts line zero. After the last byte of a body the same
//   stream state clears again.
//   Configuration: cfg_we writes register cfg_index with cfg_wdata. The user
//   must do so only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module line_grep_with_wrap_pick
  import lgwp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_body_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_line_index,
  output logic        out_line_hit,
  output logic        out_final_report,
  output logic [15:0] out_hit_total,
  output logic        out_pick_found,
  output logic [15:0] out_picked_line
);

  logic [5:0]       pattern_len_r;
  logic [PAT_BITS-1:0] pattern_r;
  logic [CUR_W-1:0] current_line_r;
  logic             direction_r;

  logic    in_fire;
  logic    is_nl;
  logic    hit_now;
  logic    produce;
  logic    skid_full;
  result_t result;
  result_t out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_len_r  <= '0;
      pattern_r      <= '0;
      current_line_r <= {CUR_W{1'b1}};
      direction_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_LEN: pattern_len_r <= cfg_wdata[5:0];
        CFG_WORD0:       pattern_r[0*64 +: 64] <= cfg_wdata;
        CFG_WORD1:       pattern_r[1*64 +: 64] <= cfg_wdata;
        CFG_WORD2:       pattern_r[2*64 +: 64] <= cfg_wdata;
        CFG_WORD3:       pattern_r[3*64 +: 64] <= cfg_wdata;
        CFG_CUR_LINE:    current_line_r <= cfg_wdata[CUR_W-1:0];
        CFG_DIRECTION:   direction_r <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  assign in_ready = !skid_full;
  assign in_fire  = in_valid && in_ready;
  assign is_nl    = (in_text_byte == NEWLINE_BYTE);

  // Prefix chain
  lgwp_chain u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (in_fire),
    .is_nl       (is_nl),
    .last        (in_body_end),
    .text_byte   (in_text_byte),
    .pattern     (pattern_r),
    .pattern_len (pattern_len_r),
    .hit_now     (hit_now)
  );

  // Counters and pick
  lgwp_tally u_tally (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (in_fire),
    .is_nl        (is_nl),
    .last         (in_body_end),
    .hit_now      (hit_now),
    .current_line (current_line_r),
    .direction    (direction_r),
    .produce      (produce),
    .result       (result)
  );

  // Result buffering
  lgwp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && produce),
    .push_data (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign out_line_index   = out_data.line_index;
  assign out_line_hit     = out_data.line_hit;
  assign out_final_report = out_data.final_report;
  assign out_hit_total    = out_data.hit_total;
  assign out_pick_found   = out_data.pick_found;
  assign out_picked_line  = out_data.picked_line;

endmodule

/* rtl/lgwp_checker.sv */
// ----------------------------------------------------------------------------
// lgwp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lgwp_checker
  import lgwp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_line_index,
  input logic        out_line_hit,
  input logic        out_final_report,
  input logic [15:0] out_hit_total,
  input logic        out_pick_found,
  input logic [15:0] out_picked_line
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_index)
      && $stable(out_hit_total) && $stable(out_picked_line))
    else $error("stalled result changed");

  // Pick fields are only set on the final report
  a_pick_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_report |-> !out_pick_found && out_picked_line == 16'd0)
    else $error("pick fields set on a non-final result");

  // A hit line is already counted in the total
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_hit |-> out_hit_total != 16'd0)
    else $error("hit line with zero total");

  // The pick is found exactly when some hit exists
  a_found_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_report |-> out_pick_found == (out_hit_total != 16'd0))
    else $error("pick_found disagrees with hit total");

endmodule

bind line_grep_with_wrap_pick lgwp_checker u_lgwp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_line_index   (out_line_index),
  .out_line_hit     (out_line_hit),
  .out_final_report (out_final_report),
  .out_hit_total    (out_hit_total),
  .out_pick_found   (out_pick_found),
  .out_picked_line  (out_picked_line)
);

/* sim/line_grep_with_wrap_pick_test.sv */
// ----------------------------------------------------------------------------
// line_grep_with_wrap_pick_test
// Self-checking bench for the per-line pattern search. A short stimulus table
// covers reset values, extremes and corner cases. Random text bodies follow,
// with the present line and direction sometimes moved between lines. A
// behavioral predictor tracks every accepted byte, and each result transaction
// is checked field by field against the oldest predicted line result. Sender
// bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module line_grep_with_wrap_pick_test;
  import lgwp_pkg::*;

  localparam int QUIET_LIMIT  = 1000;   // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 8;      // margin after the last pending result is taken
  localparam int RANDOM_BYTES = 950;
  localparam int MAX_SHOWN    = 30;

  typedef enum logic {ROW_CFG, ROW_TEXT} row_kind_t;

  // One row of the directed stimulus table
  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    logic [63:0] value;
    logic [7:0]  text;
    logic        body_end;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = '0;
  logic        in_body_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_line_index;
  logic        out_line_hit;
  logic        out_final_report;
  logic [15:0] out_hit_total;
  logic        out_pick_found;
  logic [15:0] out_picked_line;

  // Predictor copy of registers and stream state
  logic [5:0]             pat_len;
  logic [63:0]            pat_word [PAT_WORDS];
  logic signed [16:0]     cur_line;
  logic                   pick_prev;
  logic [MAX_PATTERN-1:0] run_ok;
  line_t                  line_no, hits, first_ln, last_ln, after_ln, before_ln;
  logic                   line_has_hit, after_ok, before_ok;

  result_t   line_results_q [$];
  plan_row_t plan_q [$];

  int  errors = 0;
  int  results_seen = 0;
  int  bytes_sent = 0;
  int  bodies_sent = 0;
  int  cfg_writes = 0;
  int  burst_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  line_grep_with_wrap_pick uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_body_end      (in_body_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_index   (out_line_index),
    .out_line_hit     (out_line_hit),
    .out_final_report (out_final_report),
    .out_hit_total    (out_hit_total),
    .out_pick_found   (out_pick_found),
    .out_picked_line  (out_picked_line)
  );

  // ASCII upper case to lower case, everything else unchanged
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  // Randomly swap the case of a letter
  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
        $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pattern_at(input int k);
    if (k >= PAT_CHARS) return 8'h00;
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic result_t mk_result(input line_t li, input logic hit, input logic fin,
                                        input line_t tot, input logic found,
                                        input line_t pick);
    result_t r;
    r.line_index   = li;
    r.line_hit     = hit;
    r.final_report = fin;
    r.hit_total    = tot;
    r.pick_found   = found;
    r.picked_line  = pick;
    return r;
  endfunction

  // Body text: mostly letters near the pattern, sometimes any byte at all
  function automatic logic [7:0] filler();
    case ($urandom_range(0, 15))
      0:             return 8'($urandom_range(0, 255));
      1, 2, 3, 4, 5: return flip_case(pattern_at($urandom_range(0, 7)));
      default:       return flip_case(8'h61 + 8'($urandom_range(0, 3)));
    endcase
  endfunction

  function automatic logic [63:0] pick_cur();
    case ($urandom_range(0, 9))
      0, 1:    return 64'h1_FFFF;   // no present line
      2:       return 64'h0_FFFF;
      default: return 64'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic clear_stream();
    run_ok       = '0;
    line_no      = '0;
    line_has_hit = 1'b0;
    hits         = '0;
    first_ln     = '0;
    last_ln      = '0;
    after_ln     = '0;
    after_ok     = 1'b0;
    before_ln    = '0;
    before_ok    = 1'b0;
  endtask

  // Predict the line result, if any, caused by one accepted byte
  task automatic grep_byte(input logic [7:0] b, input logic body_end,
                           output bit has_result, output result_t r);
    int eff;
    int ln;
    int cur;
    logic [7:0] fb;
    logic [MAX_PATTERN-1:0] nxt;
    eff = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    has_result = 1'b0;
    r = '0;
    // Prefix chain: cell k set when the last k+1 bytes match pattern[0..k]
    if (b == NEWLINE_BYTE) begin
      run_ok = '0;
    end else begin
      fb = to_lower(b);
      for (int k = 0; k < MAX_PATTERN; k++) begin
        nxt[k] = ((k == 0) ? 1'b1 : run_ok[k-1]) && (fb == to_lower(pattern_at(k)));
      end
      run_ok = nxt;
      if (eff > 0 && run_ok[eff-1]) line_has_hit = 1'b1;
    end
    if (b == NEWLINE_BYTE || body_end) begin
      has_result = 1'b1;
      ln  = int'(line_no);
      cur = cur_line;
      // Track hits against the present line as it stands now
      if (line_has_hit) begin
        if (hits == 0) first_ln = line_no;
        last_ln = line_no;
        if (ln > cur && !after_ok) begin
          after_ln = line_no;
          after_ok = 1'b1;
        end
        if (ln < cur) begin
          before_ln = line_no;
          before_ok = 1'b1;
        end
        if (hits != COUNT_TOP) hits = hits + 1'b1;
      end
      r.line_index   = line_no;
      r.line_hit     = line_has_hit;
      r.final_report = body_end;
      r.hit_total    = hits;
      // Wrapping pick on the last byte
      if (body_end && hits != 0) begin
        r.pick_found = 1'b1;
        if (!pick_prev) r.picked_line = (cur >= 0 && after_ok) ? after_ln : first_ln;
        else r.picked_line = (cur >= 0 && before_ok) ? before_ln : last_ln;
      end
      if (body_end) begin
        clear_stream();
      end else begin
        line_has_hit = 1'b0;
        if (line_no != COUNT_TOP) line_no = line_no + 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("mismatch on %s in result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    results_seen++;
    if (line_results_q.size() == 0) begin
      report_mismatch("result with nothing pending, line_index", got.line_index, -1);
    end else begin
      want = line_results_q.pop_front();
      if (got.line_index !== want.line_index)
        report_mismatch("line_index", got.line_index, want.line_index);
      if (got.line_hit !== want.line_hit)
        report_mismatch("line_hit", got.line_hit, want.line_hit);
      if (got.final_report !== want.final_report)
        report_mismatch("final_report", got.final_report, want.final_report);
      if (got.hit_total !== want.hit_total)
        report_mismatch("hit_total", got.hit_total, want.hit_total);
      if (got.pick_found !== want.pick_found)
        report_mismatch("pick_found", got.pick_found, want.pick_found);
      if (got.picked_line !== want.picked_line)
        report_mismatch("picked_line", got.picked_line, want.picked_line);
    end
  endtask

  // Send one byte transaction, with bursts and random gaps
  task automatic push_byte(input logic [7:0] b, input logic body_end,
                           input bit typed, input result_t want);
    bit has_result;
    result_t r;
    int gap;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_body_end  <= body_end;
    do @(posedge clk); while (in_ready !== 1'b1);
    grep_byte(b, body_end, has_result, r);
    if (typed) line_results_q.push_back(want);
    else if (has_result) line_results_q.push_back(r);
    bytes_sent++;
  endtask

  // Hold off the sender until every pending result is back
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (line_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PATTERN_LEN: pat_len     = v[5:0];
      CFG_WORD0:       pat_word[0] = v;
      CFG_WORD1:       pat_word[1] = v;
      CFG_WORD2:       pat_word[2] = v;
      CFG_WORD3:       pat_word[3] = v;
      CFG_CUR_LINE:    cur_line    = v[16:0];
      CFG_DIRECTION:   pick_prev   = v[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // New pattern, present line and direction for the next bodies
  task automatic choose_setup();
    logic [PAT_BITS-1:0] chars;
    int n;
    case ($urandom_range(0, 19))
      0, 1:    n = 0;
      2, 3:    n = MAX_PATTERN;
      4:       n = $urandom_range(MAX_PATTERN + 1, 63);
      5, 6:    n = $urandom_range(7, MAX_PATTERN - 1);
      default: n = $urandom_range(1, 6);
    endcase
    for (int k = 0; k < PAT_CHARS; k++) begin
      if ($urandom_range(0, 11) == 0) chars[k*8 +: 8] = 8'($urandom_range(0, 255));
      else chars[k*8 +: 8] = flip_case(8'h61 + 8'($urandom_range(0, 25)));
    end
    write_reg(CFG_PATTERN_LEN, 64'(n));
    write_reg(CFG_WORD0, chars[63:0]);
    write_reg(CFG_WORD1, chars[127:64]);
    write_reg(CFG_WORD2, chars[191:128]);
    write_reg(CFG_WORD3, chars[255:192]);
    write_reg(CFG_CUR_LINE, pick_cur());
    write_reg(CFG_DIRECTION, 64'($urandom_range(0, 1)));
  endtask

  // One random body: lines with whole, cut short or absent pattern copies
  task automatic send_body();
    logic [7:0] body [$];
    int nlines;
    int len;
    int eff;
    int cut;
    nlines = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
    eff = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    for (int li = 0; li < nlines; li++) begin
      len = $urandom_range(0, 6);
      for (int j = 0; j < len; j++) body.push_back(filler());
      case ($urandom_range(0, 3))
        0, 1:    cut = eff;
        2:       cut = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
        default: cut = 0;
      endcase
      for (int j = 0; j < cut; j++) body.push_back(flip_case(pattern_at(j)));
      len = $urandom_range(0, 4);
      for (int j = 0; j < len; j++) body.push_back(filler());
      if (li != nlines - 1 || $urandom_range(0, 1) == 1) body.push_back(NEWLINE_BYTE);
    end
    if (body.size() == 0) body.push_back(filler());
    foreach (body[i]) begin
      push_byte(body[i], i == body.size() - 1, 1'b0, '0);
      // Occasionally move the present line or set a new random direction mid-body
      if (body[i] == NEWLINE_BYTE && i != body.size() - 1 && $urandom_range(0, 24) == 0) begin
        settle();
        if ($urandom_range(0, 1) == 1) write_reg(CFG_CUR_LINE, pick_cur());
        else write_reg(CFG_DIRECTION, 64'($urandom_range(0, 1)));
      end
    end
    bodies_sent++;
  endtask

  // Stimulus table helpers
  task automatic add_cfg(input cfg_idx_t idx, input logic [63:0] v);
    plan_row_t row;
    row = '{kind: ROW_CFG, reg_idx: idx, value: v, text: 8'h00, body_end: 1'b0,
            typed: 1'b0, want: '0};
    plan_q.push_back(row);
  endtask

  task automatic add_text(input logic [7:0] b, input logic body_end);
    plan_row_t row;
    row = '{kind: ROW_TEXT, reg_idx: CFG_PATTERN_LEN, value: 64'h0, text: b,
            body_end: body_end, typed: 1'b0, want: '0};
    plan_q.push_back(row);
  endtask

  task automatic add_want(input logic [7:0] b, input logic body_end, input result_t w);
    plan_row_t row;
    row = '{kind: ROW_TEXT, reg_idx: CFG_PATTERN_LEN, value: 64'h0, text: b,
            body_end: body_end, typed: 1'b1, want: w};
    plan_q.push_back(row);
  endtask

  // Main stimulus
  initial begin : stimulus
    int directed_bytes;
    bit first;
    pat_len   = '0;
    cur_line  = -17'sd1;
    pick_prev = 1'b0;
    foreach (pat_word[i]) pat_word[i] = '0;
    clear_stream();

    // Reset state, empty pattern, last byte not a newline
    add_text(8'h41, 1'b0);
    add_want(NEWLINE_BYTE, 1'b0, mk_result(16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
    add_want(8'hFF, 1'b1, mk_result(16'd1, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0));
    // Mixed case pattern "aBc", next hit after line 1
    add_cfg(CFG_PATTERN_LEN, 64'd3);
    add_cfg(CFG_WORD0, 64'h63_42_61);
    add_cfg(CFG_CUR_LINE, 64'd1);
    add_cfg(CFG_DIRECTION, 64'd0);
    add_text(8'h78, 1'b0); add_text(8'h41, 1'b0); add_text(8'h62, 1'b0);
    add_text(8'h43, 1'b0); add_text(NEWLINE_BYTE, 1'b0);
    // Match split by a newline must not count
    add_text(8'h61, 1'b0); add_text(8'h62, 1'b0); add_text(NEWLINE_BYTE, 1'b0);
    add_text(8'h63, 1'b0); add_text(NEWLINE_BYTE, 1'b0);
    add_text(8'h61, 1'b0); add_text(8'h62, 1'b0); add_text(8'h63, 1'b1);
    // Newline as the last byte, no present line
    add_cfg(CFG_DIRECTION, 64'd1);
    add_cfg(CFG_CUR_LINE, {64{1'b1}});
    add_want(NEWLINE_BYTE, 1'b1, mk_result(16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0));
    // Pattern of two zero bytes
    add_cfg(CFG_PATTERN_LEN, 64'd2);
    add_cfg(CFG_WORD0, 64'h0);
    add_text(8'h00, 1'b0);
    add_want(8'h00, 1'b1, mk_result(16'd0, 1'b1, 1'b1, 16'd1, 1'b1, 16'd0));
    // Pattern holding a newline never matches
    add_cfg(CFG_WORD0, {48'h0, NEWLINE_BYTE, 8'h61});
    add_text(8'h61, 1'b0);
    add_want(NEWLINE_BYTE, 1'b0, mk_result(16'd0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0));
    add_want(8'h61, 1'b1, mk_result(16'd1, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0));
    // Length beyond the pattern store, extreme words and present line
    add_cfg(CFG_PATTERN_LEN, 64'd63);
    add_cfg(CFG_WORD0, {64{1'b1}});
    add_cfg(CFG_WORD1, 64'h0);
    add_cfg(CFG_WORD2, 64'hAAAA_5555_AAAA_5555);
    add_cfg(CFG_WORD3, {64{1'b1}});
    add_cfg(CFG_CUR_LINE, 64'h0_FFFF);
    add_cfg(CFG_DIRECTION, 64'd0);
    add_want(8'hFF, 1'b1, mk_result(16'd0, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        if (i == 0 || plan_q[i-1].kind != ROW_CFG) settle();
        write_reg(plan_q[i].reg_idx, plan_q[i].value);
      end else begin
        push_byte(plan_q[i].text, plan_q[i].body_end, plan_q[i].typed, plan_q[i].want);
      end
    end
    directed_bytes = bytes_sent;

    // Random bodies, reconfigured every few bodies
    first = 1'b1;
    while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
      if (first || $urandom_range(0, 2) == 0) begin
        settle();
        choose_setup();
      end
      send_body();
      first = 1'b0;
    end

    settle();
    $display("Covered %0d bytes in %0d bodies, %0d line results, %0d register writes.",
             bytes_sent, bodies_sent, results_seen, cfg_writes);
    $display("Included case folding, wrapping picks, long patterns and mid-body updates.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result receiver with its own stall pattern
  initial begin : take_results
    result_t seen;
    int mode;
    int mode_left;
    int run_left;
    logic ready_now;
    mode      = 0;
    mode_left = 0;
    run_left  = 0;
    ready_now = 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        seen.line_index   = out_line_index;
        seen.line_hit     = out_line_hit;
        seen.final_report = out_final_report;
        seen.hit_total    = out_hit_total;
        seen.pick_found   = out_pick_found;
        seen.picked_line  = out_picked_line;
        check_result(seen);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        0: ready_now = 1'b1;
        1: ready_now = ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            ready_now = !ready_now;
            run_left  = ready_now ? $urandom_range(1, 6) : $urandom_range(1, 8);
          end
          run_left--;
        end
      endcase
      out_ready <= ready_now;
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1) || cfg_we === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles, %0d results pending",
             QUIET_LIMIT, line_results_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
